[rtl/tsd_pkg.sv]
// package for the scratchpad temperature decoder: payload and job types,
// resolution codes and the crc-8 byte update
// no dependencies
`default_nettype none

package tsd_pkg;

  // default number of sensors
  localparam int unsigned SensorsDefault = 8;

  // depth of the queue between front and back, and of the result queue
  localparam int unsigned JobDepth = 2;
  localparam int unsigned ResDepth = 2;

  // crc-8, reflected polynomial
  localparam logic [7:0] CrcPoly = 8'h8C;

  // configuration byte resolution codes
  localparam logic [7:0] Cfg12Bit = 8'h7F;
  localparam logic [7:0] Cfg11Bit = 8'h5F;
  localparam logic [7:0] Cfg10Bit = 8'h3F;

  // scratchpad byte positions that are kept
  localparam logic [3:0] PosTempLsb  = 4'd0;
  localparam logic [3:0] PosTempMsb  = 4'd1;
  localparam logic [3:0] PosConfig   = 4'd4;
  localparam logic [3:0] PosCntRemain = 4'd6;
  localparam logic [3:0] PosCrc      = 4'd8;

  // input item
  typedef struct packed {
    logic [2:0] sensor;
    logic [7:0] data_byte;
    logic       read_failed;
  } tsd_in_t;

  // result item
  typedef struct packed {
    logic [2:0]         sensor_out;
    logic signed [19:0] temperature;
    logic               is_error;
    logic               publish;
  } tsd_out_t;

  // finished read handed from front to back
  typedef struct packed {
    logic [2:0]  sensor;
    logic        is_error;
    logic [15:0] raw;
    logic [7:0]  cfg;
    logic [7:0]  remain_cnt;
  } tsd_job_t;

  // one byte through the crc-8, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/tsd_fifo.sv]
// small register queue used between front and back and for results
// no dependencies
`default_nettype none

module tsd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/tsd_front.sv]
// front part: takes scratchpad bytes, runs the crc and keeps the bytes
// needed for decoding; emits one job per finished or failed read
// depends on tsd_pkg
`default_nettype none

module tsd_front import tsd_pkg::*; #(
  parameter int unsigned SENSORS = SensorsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    accept_i,
  input  wire tsd_in_t item_i,
  output logic         job_push_o,
  output tsd_job_t     job_o
);

  logic [3:0] byte_cnt_q, byte_cnt_d;
  logic [7:0] crc_q, crc_d;
  logic [2:0] cur_sensor_q, cur_sensor_d;
  logic [7:0] temp_lsb_q, temp_msb_q, cfg_q, cnt_remain_q;
  logic [2:0] sensor_eff;
  logic       in_range;
  logic       go;

  // sensor tag is taken only at the start of a read
  assign sensor_eff = (byte_cnt_q == '0) ? item_i.sensor : cur_sensor_q;
  assign in_range   = ({1'b0, sensor_eff} < 4'(SENSORS));
  assign go         = accept_i && in_range;

  // read sequencing and crc
  always_comb begin
    byte_cnt_d   = byte_cnt_q;
    crc_d        = crc_q;
    cur_sensor_d = cur_sensor_q;
    job_push_o   = 1'b0;
    job_o.sensor       = sensor_eff;
    job_o.is_error     = 1'b1;
    job_o.raw          = {temp_msb_q, temp_lsb_q};
    job_o.cfg          = cfg_q;
    job_o.remain_cnt   = cnt_remain_q;
    if (go) begin
      cur_sensor_d = sensor_eff;
      if (item_i.read_failed) begin
        byte_cnt_d = '0;
        crc_d      = '0;
        job_push_o = 1'b1;
      end else if (byte_cnt_q != PosCrc) begin
        crc_d      = crc8_update(crc_q, item_i.data_byte);
        byte_cnt_d = byte_cnt_q + 1'b1;
      end else begin
        byte_cnt_d     = '0;
        crc_d          = '0;
        job_push_o     = 1'b1;
        job_o.is_error = (crc_q != item_i.data_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      crc_q        <= '0;
      cur_sensor_q <= '0;
    end else begin
      byte_cnt_q   <= byte_cnt_d;
      crc_q        <= crc_d;
      cur_sensor_q <= cur_sensor_d;
    end
  end

  // kept scratchpad bytes
  always_ff @(posedge clk_i) begin
    if (go && !item_i.read_failed) begin
      if (byte_cnt_q == PosTempLsb)   temp_lsb_q   <= item_i.data_byte;
      if (byte_cnt_q == PosTempMsb)   temp_msb_q   <= item_i.data_byte;
      if (byte_cnt_q == PosConfig)    cfg_q        <= item_i.data_byte;
      if (byte_cnt_q == PosCntRemain) cnt_remain_q <= item_i.data_byte;
    end
  end

endmodule

`default_nettype wire

[rtl/tsd_back.sv]
// back part: turns a job into a temperature and applies the per-sensor
// error suppression
// depends on tsd_pkg
`default_nettype none

module tsd_back import tsd_pkg::*; #(
  parameter int unsigned SENSORS = SensorsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] fixed_res_mask_i,
  input  wire logic       job_empty_i,
  input  wire tsd_job_t   job_i,
  output logic            job_pop_o,
  input  wire logic       res_full_i,
  output logic            res_push_o,
  output tsd_out_t        res_o
);

  localparam int unsigned SelW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  logic [SENSORS-1:0] err_pend_q, err_pend_d;
  logic [SelW-1:0]    sel;
  logic               go;
  logic signed [19:0] raw_ext;
  logic signed [19:0] fixed_t;
  logic signed [19:0] temp;

  assign go         = !job_empty_i && !res_full_i;
  assign job_pop_o  = go;
  assign res_push_o = go;
  assign sel        = job_i.sensor[SelW-1:0];
  assign raw_ext    = 20'(signed'(job_i.raw));

  // extended-resolution form: half-degree bit floored, count remain subtracted
  assign fixed_t = ((raw_ext & ~20'sd1) <<< 3) + 20'sd12
                   - signed'({12'd0, job_i.remain_cnt});

  // temperature select by device kind and resolution
  always_comb begin
    if (fixed_res_mask_i[job_i.sensor]) begin
      temp = fixed_t;
    end else begin
      unique case (job_i.cfg)
        Cfg12Bit: temp = raw_ext;
        Cfg11Bit: temp = raw_ext & ~20'sd1;
        Cfg10Bit: temp = raw_ext & ~20'sd3;
        default:  temp = raw_ext & ~20'sd7;
      endcase
    end
  end

  // error suppression and result
  always_comb begin
    err_pend_d       = err_pend_q;
    res_o.sensor_out = job_i.sensor;
    res_o.is_error   = job_i.is_error;
    res_o.temperature = job_i.is_error ? 20'sd0 : temp;
    res_o.publish    = 1'b1;
    if (job_i.is_error) begin
      res_o.publish = err_pend_q[sel];
    end
    if (go) begin
      err_pend_d[sel] = job_i.is_error && !err_pend_q[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_pend_q <= '0;
    end else begin
      err_pend_q <= err_pend_d;
    end
  end

endmodule

`default_nettype wire

[rtl/temp_scratchpad_decoder_core.sv]
// top level of the scratchpad temperature decoder
// depends on tsd_pkg, tsd_front, tsd_fifo, tsd_back
//
// Bytes of a sensor scratchpad are pushed one per cycle, byte 0 to 8, or a
// read is ended early by an item with read_failed set. While full_o is
// low the front takes one item every cycle; full_o rises only when two
// finished reads wait in the two-entry job queue, which happens when
// results are not popped. A result reaches the result side after byte 8 or
// a failure item is accepted: the job queue holds it, then the back part
// writes it into a two-entry result queue; one result can be produced
// each cycle while that queue is not full. Bytes 0 to 7 produce no result.
// The user must write the fixed-resolution mask only while no read is in
// progress, through cfg_we_i/cfg_wdata_i; the block does not enforce it.
`default_nettype none

module temp_scratchpad_decoder_core import tsd_pkg::*; #(
  parameter int unsigned SENSORS = SensorsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire tsd_in_t    in_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output tsd_out_t        out_o,
  output logic            empty_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic [7:0] fixed_res_mask_q;
  logic       accept;
  logic       job_push, job_pop, job_full, job_empty;
  tsd_job_t   job_in, job_out;
  logic       res_push, res_full;
  tsd_out_t   res_in;

  assign accept = push_i && !full_o;
  assign full_o = job_full;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_res_mask_q <= '0;
    end else if (cfg_we_i) begin
      fixed_res_mask_q <= cfg_wdata_i;
    end
  end

  // byte intake and crc
  tsd_front #(.SENSORS(SENSORS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // queue of finished reads
  tsd_fifo #(.Width($bits(tsd_job_t)), .Depth(JobDepth)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // decode and error suppression
  tsd_back #(.SENSORS(SENSORS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fixed_res_mask_i (fixed_res_mask_q),
    .job_empty_i      (job_empty),
    .job_i            (job_out),
    .job_pop_o        (job_pop),
    .res_full_i       (res_full),
    .res_push_o       (res_push),
    .res_o            (res_in)
  );

  // result queue
  tsd_fifo #(.Width($bits(tsd_out_t)), .Depth(ResDepth)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (out_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

[rtl/tsd_checker.sv]
// port-level checks for the scratchpad temperature decoder, bound to the top
// depends on tsd_pkg and temp_scratchpad_decoder_core
`default_nettype none

module tsd_checker import tsd_pkg::*; #(
  parameter int unsigned SENSORS = SensorsDefault
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     pop_i,
  input wire tsd_out_t out_o,
  input wire logic     empty_o
);

  // an error result carries no temperature
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_o.is_error) |-> (out_o.temperature == 20'sd0))
    else $error("error item with nonzero temperature");

  // a waiting item does not vanish
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> !empty_o)
    else $error("result item dropped without pop");

  // a waiting item does not change
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> $stable(out_o))
    else $error("result item changed while waiting");

  // only configured sensors give results
  a_sensor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> ({1'b0, out_o.sensor_out} < 4'(SENSORS)))
    else $error("result for sensor out of range");

  // a good reading is always published
  a_good_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_o.is_error) |-> out_o.publish)
    else $error("good reading not published");

endmodule

bind temp_scratchpad_decoder_core tsd_checker #(.SENSORS(SENSORS)) u_tsd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .pop_i   (pop_i),
  .out_o   (out_o),
  .empty_o (empty_o)
);

`default_nettype wire
